@@ rtl/psc_pkg.sv @@
package psc_pkg;

  localparam int StackDepthDefault = 1024;
  localparam int DataWidth = 32;
  localparam int IndexWidth = 10;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    REQ_PUSH     = 3'd0,
    REQ_POP      = 3'd1,
    REQ_READ_TOP = 3'd2,
    REQ_READ_BOT = 3'd3,
    REQ_ADD      = 3'd4,
    REQ_SUB      = 3'd5,
    REQ_MUL      = 3'd6,
    REQ_DIV      = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_RANGE    = 3'd2,
    ERR_OPERANDS = 3'd3,
    ERR_DIVZERO  = 3'd4,
    ERR_FULL     = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ1,
    ST_READ2,
    ST_EXEC,
    ST_DIV,
    ST_WRITE,
    ST_OUT
  } state_t;

  // classified request handed from front to back
  typedef struct packed {
    req_t                  req;
    logic [DataWidth-1:0]  value;
    logic [IndexWidth-1:0] index;
  } cmd_t;

endpackage

@@ rtl/psc_front.sv @@
// Accepts requests into a small queue.
module psc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 req_type,
  input  logic [31:0]                push_value,
  input  logic [9:0]                 entry_index,
  output logic                       cmd_valid,
  input  logic                       cmd_take,
  output psc_pkg::cmd_t              cmd
);

  psc_pkg::cmd_t slots [psc_pkg::QueueDepth];
  logic          wptr;
  logic          rptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  assign in_stall  = (fill == 2'(psc_pkg::QueueDepth));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= '{req: psc_pkg::req_t'(req_type), value: push_value,
                       index: entry_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/psc_div.sv @@
// Floor divider: restoring, one quotient bit per cycle.
module psc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] ud, q, r;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [32:0] trial;

  assign trial = {r[31:0], q[31]} - {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ud  <= den[31] ? (32'd0 - den) : den;
      q   <= num[31] ? (32'd0 - num) : num;
      r   <= 32'd0;
      cnt <= 6'd0;
      neg <= num[31] ^ den[31];
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (!trial[32]) begin
        r <= trial[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= {r[30:0], q[31]};
        q <= {q[30:0], 1'b0};
      end
    end
  end

  assign quo = neg ? (32'd0 - q - 32'(r != 32'd0)) : q;

endmodule

@@ rtl/psc_back.sv @@
// Executes requests against the operand memory.
module psc_back #(
  parameter int StackDepth = psc_pkg::StackDepthDefault,
  parameter int CountWidth = $clog2(StackDepth + 1),
  parameter int AddrWidth  = $clog2(StackDepth)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_take,
  input  psc_pkg::cmd_t         cmd,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           result_value,
  output logic [2:0]            error_code,
  output logic [10:0]           depth_now
);

  localparam int IndexWidthC = psc_pkg::IndexWidth;

  logic [31:0]           mem [StackDepth];
  logic [31:0]           rdata;
  logic [AddrWidth-1:0]  raddr;
  logic                  wen;
  logic [AddrWidth-1:0]  waddr;
  logic [31:0]           wdata;

  psc_pkg::state_t       state, state_next;
  psc_pkg::cmd_t         cur;
  logic [CountWidth-1:0] count;
  logic [31:0]           top;
  logic [31:0]           prod;
  logic                  div_start, div_done;
  logic [31:0]           div_quo;
  logic [CountWidth-1:0] idx_ext;
  psc_pkg::err_t         err;

  assign idx_ext = CountWidth'(cur.index);

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  psc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(rdata), .den(top),
    .done(div_done), .quo(div_quo)
  );

  // error check on the request held in cur
  always_comb begin
    err = psc_pkg::ERR_OK;
    case (cur.req)
      psc_pkg::REQ_PUSH:
        if (count >= CountWidth'(StackDepth)) err = psc_pkg::ERR_FULL;
      psc_pkg::REQ_POP:
        if (count == '0) err = psc_pkg::ERR_EMPTY;
      psc_pkg::REQ_READ_TOP, psc_pkg::REQ_READ_BOT:
        if ((CountWidth > IndexWidthC) ? (idx_ext >= count)
            : ({1'b0, cur.index} >= 11'(count))) err = psc_pkg::ERR_RANGE;
      default:
        if (count < CountWidth'(2)) err = psc_pkg::ERR_OPERANDS;
    endcase
  end

  always_comb begin
    raddr = '0;
    case (state)
      psc_pkg::ST_IDLE: raddr = '0;
      default: begin
        if (state == psc_pkg::ST_READ1) begin
          case (cur.req)
            psc_pkg::REQ_READ_TOP:
              raddr = AddrWidth'(count - CountWidth'(1) - idx_ext);
            psc_pkg::REQ_READ_BOT: raddr = AddrWidth'(cur.index);
            default: raddr = AddrWidth'(count - CountWidth'(1));
          endcase
        end else begin
          raddr = AddrWidth'(count - CountWidth'(2));
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      psc_pkg::ST_IDLE:  if (cmd_valid) state_next = psc_pkg::ST_READ1;
      psc_pkg::ST_READ1: begin
        if (err != psc_pkg::ERR_OK || cur.req == psc_pkg::REQ_PUSH)
          state_next = psc_pkg::ST_OUT;
        else if (cur.req == psc_pkg::REQ_POP || cur.req == psc_pkg::REQ_READ_TOP
                 || cur.req == psc_pkg::REQ_READ_BOT)
          state_next = psc_pkg::ST_EXEC;
        else
          state_next = psc_pkg::ST_READ2;
      end
      psc_pkg::ST_READ2: state_next = psc_pkg::ST_EXEC;
      psc_pkg::ST_EXEC: begin
        if (cur.req == psc_pkg::REQ_DIV && top != 32'd0) state_next = psc_pkg::ST_DIV;
        else if (cur.req == psc_pkg::REQ_ADD || cur.req == psc_pkg::REQ_SUB
                 || cur.req == psc_pkg::REQ_MUL) state_next = psc_pkg::ST_WRITE;
        else state_next = psc_pkg::ST_OUT;
      end
      psc_pkg::ST_DIV:   if (div_done) state_next = psc_pkg::ST_WRITE;
      psc_pkg::ST_WRITE: state_next = psc_pkg::ST_OUT;
      psc_pkg::ST_OUT:   if (!out_stall) state_next = psc_pkg::ST_IDLE;
      default:           state_next = psc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take  = (state == psc_pkg::ST_IDLE) && cmd_valid;
    out_valid = (state == psc_pkg::ST_OUT);
    div_start = (state == psc_pkg::ST_EXEC) && cur.req == psc_pkg::REQ_DIV
                && top != 32'd0;
    wen   = 1'b0;
    waddr = AddrWidth'(count - CountWidth'(1));
    wdata = result_value;
    if (state == psc_pkg::ST_READ1 && err == psc_pkg::ERR_OK
        && cur.req == psc_pkg::REQ_PUSH) begin
      wen   = 1'b1;
      waddr = AddrWidth'(count);
      wdata = cur.value;
    end else if (state == psc_pkg::ST_WRITE) begin
      // result replaces the second entry
      wen   = 1'b1;
      waddr = AddrWidth'(count - CountWidth'(2));
      wdata = (cur.req == psc_pkg::REQ_MUL) ? prod : result_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psc_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == psc_pkg::ST_READ1 && err == psc_pkg::ERR_OK) begin
        if (cur.req == psc_pkg::REQ_PUSH) count <= count + CountWidth'(1);
        else if (cur.req == psc_pkg::REQ_POP) count <= count - CountWidth'(1);
      end
      if (state == psc_pkg::ST_WRITE) count <= count - CountWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    prod <= 32'(rdata * top);
    case (state)
      psc_pkg::ST_IDLE: if (cmd_valid) cur <= cmd;
      psc_pkg::ST_READ1: begin
        error_code   <= err;
        result_value <= 32'd0;
      end
      psc_pkg::ST_READ2: top <= rdata;
      psc_pkg::ST_EXEC: begin
        case (cur.req)
          psc_pkg::REQ_ADD: result_value <= rdata + top;
          psc_pkg::REQ_SUB: result_value <= rdata - top;
          psc_pkg::REQ_DIV: if (top == 32'd0) error_code <= psc_pkg::ERR_DIVZERO;
          psc_pkg::REQ_MUL: ;
          default: result_value <= rdata;
        endcase
      end
      psc_pkg::ST_DIV: if (div_done) result_value <= div_quo;
      default: ;
    endcase
    if (state == psc_pkg::ST_WRITE && cur.req == psc_pkg::REQ_MUL) result_value <= prod;
  end

  // memory is written in ST_WRITE with result_value; for multiply use prod
  assign depth_now = 11'(count);

endmodule

@@ rtl/postfix_stack_calculator_top.sv @@
// Postfix stack calculator: a STACK_DEPTH-entry stack of 32-bit signed
// operands. Each request returns one result with a value, an error code and
// the depth after the request. The back end steps a push, or any request that
// fails its operand check, from ST_READ1 to ST_OUT; pop and reads add ST_EXEC,
// add/subtract/multiply add ST_READ2, ST_EXEC and ST_WRITE, and a divide by a
// nonzero divisor also adds ST_DIV (a 32-step bit-serial divider). The result waits in ST_OUT on out_stall.
// A two-entry request queue in front accepts while the back end works.
module postfix_stack_calculator_top #(
  parameter int STACK_DEPTH = psc_pkg::StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] push_value,
  input  logic [9:0]  entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic [2:0]  error_code,
  output logic [10:0] depth_now
);

  logic          cmd_valid;
  logic          cmd_take;
  psc_pkg::cmd_t cmd;

  psc_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .push_value(push_value), .entry_index(entry_index),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  psc_back #(.StackDepth(STACK_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_valid(out_valid), .out_stall(out_stall), .result_value(result_value),
    .error_code(error_code), .depth_now(depth_now)
  );

endmodule

@@ rtl/psc_checker.sv @@
module psc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result_value,
  input logic [2:0]  error_code,
  input logic [10:0] depth_now
);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != psc_pkg::ERR_OK |-> result_value == 32'd0)
    else $error("nonzero value on error");

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code <= psc_pkg::ERR_FULL)
    else $error("bad error code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value))
    else $error("stalled result changed");

  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == psc_pkg::ERR_FULL |-> depth_now != 11'd0)
    else $error("full with zero depth");

endmodule

bind postfix_stack_calculator_top psc_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .result_value(result_value), .error_code(error_code), .depth_now(depth_now)
);

@@ tb/sv/postfix_stack_calculator_top_test.sv @@
`timescale 1ns / 1ps

module postfix_stack_calculator_top_test;

  localparam int Depth = psc_pkg::StackDepthDefault;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [31:0]    value;
    psc_pkg::err_t  err;
    logic [10:0]    depth;
  } calc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [31:0] push_value = '0;
  logic [9:0]  entry_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_value;
  logic [2:0]  error_code;
  logic [10:0] depth_now;

  logic [31:0]  shadow_stack [Depth];
  int unsigned  shadow_count = 0;
  calc_result_t pending_results [$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           next_gap = 0;
  int           out_wait = 0;
  bit           hold_output = 1'b0;
  bit           no_idle = 1'b0;

  postfix_stack_calculator_top dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("postfix_stack_calculator_top: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] floor_div(logic [31:0] num, logic [31:0] den);
    logic [31:0] un, ud, quo, rem;
    un = num[31] ? -num : num;
    ud = den[31] ? -den : den;
    quo = un / ud;
    rem = un % ud;
    if (num[31] ^ den[31]) return -quo - (rem != 0 ? 32'd1 : 32'd0);
    return quo;
  endfunction

  function automatic calc_result_t apply_request(psc_pkg::req_t req, logic [31:0] val,
                                                 logic [9:0] idx);
    calc_result_t r;
    logic [31:0] top, second;
    r.value = '0;
    r.err = psc_pkg::ERR_OK;
    case (req)
      psc_pkg::REQ_PUSH: begin
        if (shadow_count >= Depth) r.err = psc_pkg::ERR_FULL;
        else begin
          shadow_stack[shadow_count] = val;
          shadow_count++;
        end
      end
      psc_pkg::REQ_POP: begin
        if (shadow_count == 0) r.err = psc_pkg::ERR_EMPTY;
        else begin
          shadow_count--;
          r.value = shadow_stack[shadow_count];
        end
      end
      psc_pkg::REQ_READ_TOP: begin
        if (idx >= shadow_count) r.err = psc_pkg::ERR_RANGE;
        else r.value = shadow_stack[shadow_count - 1 - idx];
      end
      psc_pkg::REQ_READ_BOT: begin
        if (idx >= shadow_count) r.err = psc_pkg::ERR_RANGE;
        else r.value = shadow_stack[idx];
      end
      default: begin
        if (shadow_count < 2) r.err = psc_pkg::ERR_OPERANDS;
        else begin
          top = shadow_stack[shadow_count - 1];
          second = shadow_stack[shadow_count - 2];
          case (req)
            psc_pkg::REQ_ADD: r.value = second + top;
            psc_pkg::REQ_SUB: r.value = second - top;
            psc_pkg::REQ_MUL: r.value = second * top;
            default: begin
              if (top == 0) r.err = psc_pkg::ERR_DIVZERO;
              else r.value = floor_div(second, top);
            end
          endcase
          if (r.err == psc_pkg::ERR_OK) begin
            shadow_count--;
            shadow_stack[shadow_count - 1] = r.value;
          end
        end
      end
    endcase
    if (r.err != psc_pkg::ERR_OK) r.value = '0;
    r.depth = shadow_count[10:0];
    return r;
  endfunction

  // the idle gap before the next request is drawn when the current one is taken
  task automatic send_request(psc_pkg::req_t req, logic [31:0] val, logic [9:0] idx);
    repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    req_type <= req;
    push_value <= val;
    entry_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_request(req, val, idx));
    next_gap = no_idle ? 0 : $urandom_range(0, 3);
    if (next_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic release_input();
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
  endtask

  // receiver: may stall after each result, or holds off for a long stretch
  always @(posedge clk) begin
    int w;
    if (out_valid && !out_stall) w = no_idle ? 0 : $urandom_range(0, 3);
    else w = (out_wait > 0) ? out_wait - 1 : 0;
    out_wait <= w;
    out_stall <= hold_output || (w != 0);
  end

  always @(posedge clk) begin
    calc_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_value !== exp_r.value) begin
          $error("result_value exp %h got %h", exp_r.value, result_value);
          fail_count++;
        end
        if (error_code !== exp_r.err) begin
          $error("error_code exp %0d got %0d", exp_r.err, error_code);
          fail_count++;
        end
        if (depth_now !== exp_r.depth) begin
          $error("depth_now exp %0d got %0d", exp_r.depth, depth_now);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_errors();
    send_request(psc_pkg::REQ_POP, '0, '0);
    send_request(psc_pkg::REQ_READ_TOP, '0, '0);
    send_request(psc_pkg::REQ_READ_BOT, '0, 10'h3ff);
    send_request(psc_pkg::REQ_ADD, '0, '0);
    send_request(psc_pkg::REQ_PUSH, 32'd5, '0);
    send_request(psc_pkg::REQ_DIV, '0, '0);
  endtask

  task automatic test_arith_edges();
    send_request(psc_pkg::REQ_PUSH, 32'h8000_0000, 10'h3ff);
    send_request(psc_pkg::REQ_PUSH, 32'hffff_ffff, '0);
    send_request(psc_pkg::REQ_DIV, '0, '0);
    send_request(psc_pkg::REQ_PUSH, 32'd0, '0);
    send_request(psc_pkg::REQ_DIV, '0, '0);
    send_request(psc_pkg::REQ_POP, '0, '0);
    send_request(psc_pkg::REQ_PUSH, -32'sd7, '0);
    send_request(psc_pkg::REQ_PUSH, 32'd2, '0);
    send_request(psc_pkg::REQ_DIV, '0, '0);
    send_request(psc_pkg::REQ_PUSH, 32'h7fff_ffff, '0);
    send_request(psc_pkg::REQ_ADD, '0, '0);
    send_request(psc_pkg::REQ_PUSH, 32'h7fff_ffff, '0);
    send_request(psc_pkg::REQ_MUL, '0, '0);
    send_request(psc_pkg::REQ_PUSH, 32'd3, '0);
    send_request(psc_pkg::REQ_SUB, '0, '0);
    send_request(psc_pkg::REQ_READ_TOP, '0, 10'd1);
    send_request(psc_pkg::REQ_READ_BOT, '0, 10'd1);
    send_request(psc_pkg::REQ_READ_BOT, '0, 10'd2);
  endtask

  task automatic test_backpressure();
    int k;
    fork
      begin
        hold_output = 1'b1;
        repeat (200) @(posedge clk);
        hold_output = 1'b0;
      end
      begin
        for (k = 0; k < 12; k++) send_request(psc_pkg::REQ_PUSH, $urandom, '0);
        release_input();
      end
    join
  endtask

  task automatic test_random_mix();
    int k;
    psc_pkg::req_t r;
    for (k = 0; k < 240; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: r = psc_pkg::REQ_PUSH;
        3: r = psc_pkg::REQ_POP;
        4: r = psc_pkg::REQ_READ_TOP;
        5: r = psc_pkg::REQ_READ_BOT;
        default: r = psc_pkg::req_t'($urandom_range(4, 7));
      endcase
      if (shadow_count < 3 && $urandom_range(0, 3) != 0) r = psc_pkg::REQ_PUSH;
      send_request(r, rand_operand(),
                   $urandom_range(0, 3) == 0 ? 10'($urandom) :
                   10'($urandom_range(0, shadow_count + 1)));
    end
  endtask

  task automatic test_full_stack();
    no_idle = 1'b1;
    while (shadow_count < Depth) send_request(psc_pkg::REQ_PUSH, rand_operand(), '0);
    no_idle = 1'b0;
    send_request(psc_pkg::REQ_PUSH, 32'h1234_5678, '0);
    send_request(psc_pkg::REQ_READ_TOP, '0, 10'h3ff);
    send_request(psc_pkg::REQ_READ_BOT, '0, 10'h3ff);
    send_request(psc_pkg::REQ_READ_BOT, '0, '0);
    send_request(psc_pkg::REQ_POP, '0, '0);
    send_request(psc_pkg::REQ_ADD, '0, '0);
    send_request(psc_pkg::REQ_PUSH, 32'd3, '0);
    send_request(psc_pkg::REQ_DIV, '0, '0);
    send_request(psc_pkg::REQ_READ_TOP, '0, '0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_errors();
    test_arith_edges();
    test_backpressure();
    test_random_mix();
    test_full_stack();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("postfix_stack_calculator_top: match");
    else $display("postfix_stack_calculator_top: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_div.sv
rtl/psc_back.sv
rtl/postfix_stack_calculator_top.sv
rtl/psc_checker.sv
tb/sv/postfix_stack_calculator_top_test.sv
